// ===== rtl/core/connection_slot_pool_with_timeouts_defines.svh =====
// ----------------------------------------------------------------------------
// Connection slot pool assertion macros
// Shared concurrent assertion forms for the slot pool RTL.
// ----------------------------------------------------------------------------
`ifndef CONNECTION_SLOT_POOL_WITH_TIMEOUTS_DEFINES_SVH
`define CONNECTION_SLOT_POOL_WITH_TIMEOUTS_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define CSP_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define CSP_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/csp_pkg.sv =====
// ----------------------------------------------------------------------------
// Connection slot pool package
// Types, codes and reset values shared by the slot cells and the controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package csp_pkg;

	// Default pool depth and sweep result cap
	localparam int POOL_SIZE_DEF = 16;
	localparam int MAX_RESULTS   = 16;
	localparam int TIME_W        = 32;
	localparam int CNT_W         = 5;

	// Register reset values
	localparam logic [CNT_W-1:0]  MAX_CONN_RST     = 5'd16;
	localparam logic [TIME_W-1:0] IDLE_TIMEOUT_RST = 32'd30;
	localparam logic [TIME_W-1:0] MAX_AGE_RST      = 32'd300;

	// Command codes carried on the input tuser
	typedef enum logic [1:0] {
		CMD_ALLOC   = 2'd0,
		CMD_RELEASE = 2'd1,
		CMD_TOUCH   = 2'd2,
		CMD_SWEEP   = 2'd3
	} cmd_t;

	// Result status codes carried on the output tuser
	typedef enum logic [1:0] {
		STS_OK           = 2'd0,
		STS_FULL         = 2'd1,
		STS_NOT_ACTIVE   = 2'd2,
		STS_NONE_EXPIRED = 2'd3
	} status_t;

	// Per-slot life cycle
	typedef enum logic [1:0] {
		SLOT_IDLE    = 2'd0,
		SLOT_ACTIVE  = 2'd1,
		SLOT_CLOSING = 2'd2
	} slot_state_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_MAX_CONN     = 2'd0,
		REG_IDLE_TIMEOUT = 2'd1,
		REG_MAX_AGE      = 2'd2
	} reg_idx_t;

	// Update applied to a selected cell
	typedef enum logic [1:0] {
		OP_NOP   = 2'd0,
		OP_ALLOC = 2'd1,
		OP_CLOSE = 2'd2,
		OP_TOUCH = 2'd3
	} cell_op_t;

	// Controller states
	typedef enum logic [1:0] {
		CS_IDLE  = 2'd0,
		CS_EXEC  = 2'd1,
		CS_SWEEP = 2'd2,
		CS_FIN   = 2'd3
	} ctl_state_t;

	// Broadcast control from the controller to every cell
	typedef struct packed {
		cell_op_t op;
		logic     adv;
		logic     clr;
	} cell_ctl_t;

	// Status reported by one cell
	typedef struct packed {
		slot_state_t state;
		logic        expired;
		logic        tok;
	} cell_stat_t;

endpackage

// ===== rtl/core/csp_cell.sv =====
// ----------------------------------------------------------------------------
// Connection slot pool cell
// Holds one slot: life cycle state, free-list link, time stamps and the sweep
// token, which it hands to the next cell when the controller advances.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csp_cell #(
	parameter int POOL_SIZE = csp_pkg::POOL_SIZE_DEF,
	parameter int IDX       = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  csp_pkg::cell_ctl_t            ctl,
	input  logic                          sel,
	input  logic                          tok_in,
	input  logic [$clog2(POOL_SIZE+1)-1:0] link_in,
	input  logic [csp_pkg::TIME_W-1:0]    now,
	input  logic [csp_pkg::TIME_W-1:0]    idle_timeout,
	input  logic [csp_pkg::TIME_W-1:0]    max_age,
	output csp_pkg::cell_stat_t           stat,
	output logic [$clog2(POOL_SIZE+1)-1:0] link
);

	localparam int LW = $clog2(POOL_SIZE + 1);

	csp_pkg::slot_state_t        state_q;
	logic [LW-1:0]               link_q;
	logic                        tok_q;
	logic [csp_pkg::TIME_W-1:0]  lat_q;
	logic [csp_pkg::TIME_W-1:0]  cre_q;
	logic [csp_pkg::TIME_W-1:0]  idle_age;
	logic [csp_pkg::TIME_W-1:0]  life_age;

	// Ages wrap modulo the time stamp width
	assign idle_age = now - lat_q;
	assign life_age = now - cre_q;

	// Report state; expiry counts only while this cell holds the token
	assign stat.state   = state_q;
	assign stat.tok     = tok_q;
	assign stat.expired = tok_q && (state_q == csp_pkg::SLOT_ACTIVE) &&
		((idle_age > idle_timeout) || (life_age > max_age));
	assign link         = link_q;

	// Update state, link and token
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= csp_pkg::SLOT_IDLE;
			link_q  <= LW'(IDX + 1);
			tok_q   <= 1'b0;
		end else begin
			if (ctl.clr) begin
				tok_q <= 1'b0;
			end else if (ctl.adv) begin
				tok_q <= tok_in;
			end
			if (sel) begin
				unique case (ctl.op)
					csp_pkg::OP_ALLOC: begin
						state_q <= csp_pkg::SLOT_ACTIVE;
					end
					csp_pkg::OP_CLOSE: begin
						state_q <= csp_pkg::SLOT_CLOSING;
						link_q  <= link_in;
					end
					csp_pkg::OP_TOUCH: begin
					end
					csp_pkg::OP_NOP: begin
					end
				endcase
			end
		end
	end

	// Stamp activity and creation times
	always_ff @(posedge clk) begin
		if (sel) begin
			unique case (ctl.op)
				csp_pkg::OP_ALLOC: begin
					lat_q <= now;
					cre_q <= now;
				end
				csp_pkg::OP_CLOSE, csp_pkg::OP_TOUCH: begin
					lat_q <= now;
				end
				csp_pkg::OP_NOP: begin
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/connection_slot_pool_with_timeouts.sv =====
// ----------------------------------------------------------------------------
// Connection slot pool with timeouts
// Free-list slot allocator over a chain of slot cells, with a sweep token
// that walks the chain and retires idle or over-age slots.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | contents
//  s_*      | in        | s_tvalid/s_tready  | command, slot index, time stamp
//  m_*      | out       | m_tvalid/m_tready  | status, slot, active count, last
//  cfg_*    | in        | cfg_we             | max_connections, idle/age limits
//
//  Allocate, release and touch are taken in the transfer, then CS_EXEC reads
//  the addressed cell and writes it back once the output register is free.
//  In a sweep the token steps one cell per cycle, but a second expiry waits,
//  and the token with it, while the previous result still sits in the
//  output register.
//  Reset clears every cell at once; no clearing pass is needed.
//  A stalled output holds the input side off only once the next result is due.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "connection_slot_pool_with_timeouts_defines.svh"

module connection_slot_pool_with_timeouts #(
	parameter int POOL_SIZE = csp_pkg::POOL_SIZE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// s_tdata: slot_index[3:0], now[35:4], zero pad[39:36]
	input  logic [39:0] s_tdata,
	// s_tuser: cmd[1:0]
	input  logic [1:0]  s_tuser,
	input  logic        s_tvalid,
	output logic        s_tready,
	// m_tdata: slot_out[3:0], active_count[8:4], zero pad[15:9]
	output logic [15:0] m_tdata,
	// m_tuser: status[1:0]
	output logic [1:0]  m_tuser,
	output logic        m_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);

	localparam int LW  = $clog2(POOL_SIZE + 1);
	localparam int IW  = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
	localparam int NW  = $clog2(csp_pkg::MAX_RESULTS + 1);
	localparam int CW  = csp_pkg::CNT_W;
	localparam int TW  = csp_pkg::TIME_W;

	// Controller registers
	csp_pkg::ctl_state_t state_q, state_d;
	csp_pkg::cmd_t       cmd_q, cmd_d;
	logic [3:0]          idx_q, idx_d;
	logic [TW-1:0]       now_q, now_d;
	logic [LW-1:0]       head_q, head_d;
	logic [CW-1:0]       count_q, count_d;
	logic [IW-1:0]       pos_q, pos_d;
	logic [NW-1:0]       n_q, n_d;
	logic                pend_q, pend_d;
	logic [3:0]          pend_slot_q, pend_slot_d;
	logic [CW-1:0]       pend_cnt_q, pend_cnt_d;

	// Configuration registers
	logic [CW-1:0]       maxc_q;
	logic [TW-1:0]       idle_q;
	logic [TW-1:0]       age_q;

	// Output register
	logic                m_valid_q, m_valid_d;
	csp_pkg::status_t    m_sts_q, m_sts_d;
	logic [3:0]          m_slot_q, m_slot_d;
	logic [CW-1:0]       m_cnt_q, m_cnt_d;
	logic                m_last_q, m_last_d;

	// Cell chain signals
	csp_pkg::cell_ctl_t  ctl;
	logic [POOL_SIZE-1:0] sel;
	logic [POOL_SIZE-1:0] tok_vec;
	logic [POOL_SIZE-1:0] tok_in_w;
	logic [POOL_SIZE-1:0] exp_vec;
	logic [POOL_SIZE-1:0] idx_dec;
	logic [POOL_SIZE-1:0] head_dec;
	logic                tok0;
	csp_pkg::cell_stat_t stat [POOL_SIZE];
	logic [LW-1:0]       link_vec [POOL_SIZE];

	// Read paths
	logic [1:0]          idx_state;
	logic [LW-1:0]       head_link;
	logic                idx_active;
	logic                head_null;
	logic                exp_here;
	logic                out_free;
	logic [CW-1:0]       cnt_dec;

	// Build the chain of slot cells
	genvar g;
	generate
		for (g = 0; g < POOL_SIZE; g++) begin : g_cell
			if (g == 0) begin : g_first
				assign tok_in_w[g] = tok0;
			end else begin : g_next
				assign tok_in_w[g] = tok_vec[g-1];
			end
			csp_cell #(
				.POOL_SIZE(POOL_SIZE),
				.IDX      (g)
			) u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctl         (ctl),
				.sel         (sel[g]),
				.tok_in      (tok_in_w[g]),
				.link_in     (head_q),
				.now         (now_q),
				.idle_timeout(idle_q),
				.max_age     (age_q),
				.stat        (stat[g]),
				.link        (link_vec[g])
			);
			assign tok_vec[g]  = stat[g].tok;
			assign exp_vec[g]  = stat[g].expired;
			assign idx_dec[g]  = (32'(idx_q) == 32'(g));
			assign head_dec[g] = (head_q == LW'(g));
		end
	endgenerate

	// Select the addressed cell's state and the head cell's link
	always_comb begin
		idx_state = '0;
		head_link = '0;
		for (int i = 0; i < POOL_SIZE; i++) begin
			idx_state = idx_state | (stat[i].state & {2{idx_dec[i]}});
			head_link = head_link | (link_vec[i] & {LW{head_dec[i]}});
		end
	end

	assign idx_active = (idx_state == csp_pkg::SLOT_ACTIVE);
	assign head_null  = (head_q == LW'(POOL_SIZE));
	assign exp_here   = |exp_vec;
	assign out_free   = !m_valid_q || m_tready;
	assign cnt_dec    = (count_q != '0) ? (count_q - CW'(1)) : count_q;

	// Next state, cell control and result
	always_comb begin
		state_d     = state_q;
		cmd_d       = cmd_q;
		idx_d       = idx_q;
		now_d       = now_q;
		head_d      = head_q;
		count_d     = count_q;
		pos_d       = pos_q;
		n_d         = n_q;
		pend_d      = pend_q;
		pend_slot_d = pend_slot_q;
		pend_cnt_d  = pend_cnt_q;
		m_valid_d   = m_valid_q && !m_tready;
		m_sts_d     = m_sts_q;
		m_slot_d    = m_slot_q;
		m_cnt_d     = m_cnt_q;
		m_last_d    = m_last_q;
		ctl.op      = csp_pkg::OP_NOP;
		ctl.adv     = 1'b0;
		ctl.clr     = 1'b0;
		sel         = '0;
		tok0        = 1'b0;
		s_tready    = (state_q == csp_pkg::CS_IDLE);

		unique case (state_q)
			csp_pkg::CS_IDLE: begin
				cmd_d = csp_pkg::cmd_t'(s_tuser);
				idx_d = s_tdata[3:0];
				now_d = s_tdata[35:4];
				if (s_tvalid) begin
					if (csp_pkg::cmd_t'(s_tuser) == csp_pkg::CMD_SWEEP) begin
						// load the token into the first cell
						ctl.adv = 1'b1;
						tok0    = 1'b1;
						pos_d   = '0;
						n_d     = '0;
						pend_d  = 1'b0;
						state_d = csp_pkg::CS_SWEEP;
					end else begin
						state_d = csp_pkg::CS_EXEC;
					end
				end
			end

			csp_pkg::CS_EXEC: begin
				if (out_free) begin
					m_valid_d = 1'b1;
					m_last_d  = 1'b1;
					m_cnt_d   = count_q;
					state_d   = csp_pkg::CS_IDLE;
					unique case (cmd_q)
						csp_pkg::CMD_ALLOC: begin
							if ((count_q >= maxc_q) || head_null) begin
								m_sts_d  = csp_pkg::STS_FULL;
								m_slot_d = '0;
							end else begin
								// pop the head slot
								ctl.op   = csp_pkg::OP_ALLOC;
								sel      = head_dec;
								head_d   = head_link;
								count_d  = count_q + CW'(1);
								m_sts_d  = csp_pkg::STS_OK;
								m_slot_d = 4'(head_q);
								m_cnt_d  = count_q + CW'(1);
							end
						end
						csp_pkg::CMD_RELEASE, csp_pkg::CMD_TOUCH: begin
							m_slot_d = idx_q;
							if (!idx_active) begin
								m_sts_d = csp_pkg::STS_NOT_ACTIVE;
							end else begin
								m_sts_d = csp_pkg::STS_OK;
								sel     = idx_dec;
								if (cmd_q == csp_pkg::CMD_RELEASE) begin
									// push the slot back on the free stack
									ctl.op  = csp_pkg::OP_CLOSE;
									head_d  = LW'(idx_q);
									count_d = cnt_dec;
									m_cnt_d = cnt_dec;
								end else begin
									ctl.op = csp_pkg::OP_TOUCH;
								end
							end
						end
						csp_pkg::CMD_SWEEP: begin
						end
					endcase
				end
			end

			csp_pkg::CS_SWEEP: begin
				if (n_q == NW'(csp_pkg::MAX_RESULTS)) begin
					state_d = csp_pkg::CS_FIN;
				end else if (!exp_here || !pend_q || out_free) begin
					if (exp_here) begin
						// retire the token cell, hand out the previous expiry
						ctl.op      = csp_pkg::OP_CLOSE;
						sel         = tok_vec;
						head_d      = LW'(pos_q);
						count_d     = cnt_dec;
						n_d         = n_q + NW'(1);
						if (pend_q) begin
							m_valid_d = 1'b1;
							m_sts_d   = csp_pkg::STS_OK;
							m_slot_d  = pend_slot_q;
							m_cnt_d   = pend_cnt_q;
							m_last_d  = 1'b0;
						end
						pend_d      = 1'b1;
						pend_slot_d = 4'(pos_q);
						pend_cnt_d  = cnt_dec;
					end
					// advance the token one cell
					ctl.adv = 1'b1;
					pos_d   = pos_q + IW'(1);
					if (pos_q == IW'(POOL_SIZE - 1)) begin
						state_d = csp_pkg::CS_FIN;
					end
				end
			end

			csp_pkg::CS_FIN: begin
				ctl.clr = 1'b1;
				if (out_free) begin
					m_valid_d = 1'b1;
					m_last_d  = 1'b1;
					if (pend_q) begin
						m_sts_d  = csp_pkg::STS_OK;
						m_slot_d = pend_slot_q;
						m_cnt_d  = pend_cnt_q;
					end else begin
						m_sts_d  = csp_pkg::STS_NONE_EXPIRED;
						m_slot_d = '0;
						m_cnt_d  = count_q;
					end
					pend_d  = 1'b0;
					state_d = csp_pkg::CS_IDLE;
				end
			end
		endcase
	end

	// Controller state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= csp_pkg::CS_IDLE;
			head_q    <= '0;
			count_q   <= '0;
			pend_q    <= 1'b0;
			n_q       <= '0;
			pos_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			head_q    <= head_d;
			count_q   <= count_d;
			pend_q    <= pend_d;
			n_q       <= n_d;
			pos_q     <= pos_d;
			m_valid_q <= m_valid_d;
		end
	end

	// Hold the command and result payload
	always_ff @(posedge clk) begin
		cmd_q       <= cmd_d;
		idx_q       <= idx_d;
		now_q       <= now_d;
		pend_slot_q <= pend_slot_d;
		pend_cnt_q  <= pend_cnt_d;
		m_sts_q     <= m_sts_d;
		m_slot_q    <= m_slot_d;
		m_cnt_q     <= m_cnt_d;
		m_last_q    <= m_last_d;
	end

	// Configuration writes keep the low bits of the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			maxc_q <= csp_pkg::MAX_CONN_RST;
			idle_q <= csp_pkg::IDLE_TIMEOUT_RST;
			age_q  <= csp_pkg::MAX_AGE_RST;
		end else if (cfg_we) begin
			unique case (csp_pkg::reg_idx_t'(cfg_index))
				csp_pkg::REG_MAX_CONN:     maxc_q <= cfg_wdata[CW-1:0];
				csp_pkg::REG_IDLE_TIMEOUT: idle_q <= cfg_wdata[TW-1:0];
				csp_pkg::REG_MAX_AGE:      age_q  <= cfg_wdata[TW-1:0];
				default: begin
				end
			endcase
		end
	end

	// Drive the output channel
	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_sts_q;
	assign m_tlast  = m_last_q;
	assign m_tdata  = {7'b0, m_cnt_q, m_slot_q};

	// Sweep token and free-list consistency
	`CSP_ASSERT_NOW(a_tok_onehot0, clk, arst_n, 1'b1, $onehot0(tok_vec), "more than one sweep token")
	`CSP_ASSERT_NOW(a_tok_at_pos, clk, arst_n, state_q == csp_pkg::CS_SWEEP, tok_vec[pos_q], "sweep token not at position")
	`CSP_ASSERT_NOW(a_idle_no_tok, clk, arst_n, state_q == csp_pkg::CS_IDLE, tok_vec == '0, "token left after sweep")
	`CSP_ASSERT_NOW(a_pend_in_sweep, clk, arst_n, pend_q, (state_q == csp_pkg::CS_SWEEP) || (state_q == csp_pkg::CS_FIN), "pending expiry outside sweep")
	`CSP_ASSERT_NOW(a_free_not_empty, clk, arst_n, 32'(count_q) < POOL_SIZE, !head_null, "free stack empty below pool size")

endmodule
